>>> rtl/fat16_cluster_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each helper takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef FAT16_CLUSTER_ALLOCATOR_MACROS_SVH
`define FAT16_CLUSTER_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define FATCA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fatca: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FATCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fatca: next-cycle check failed");

`else

`define FATCA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FATCA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fatca_pkg.sv
package fatca_pkg;

    localparam int DATA_W          = 16;
    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [DATA_W-1:0] FIRST_DATA  = 16'd2;
    localparam logic [DATA_W-1:0] END_MIN     = 16'hFFF8;
    localparam logic [DATA_W-1:0] END_MARK    = 16'hFFFF;
    localparam logic [DATA_W-1:0] MEDIA_MARK  = 16'hFFF8;
    localparam logic [DATA_W-1:0] TOTAL_RESET = 16'd4085;

    // Register select: bit APB_AW-1 of the byte address
    localparam logic REG_CLUSTER_TOTAL = 1'b0;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_FREE   = 3'd3,
        OP_COUNT  = 3'd4,
        OP_REWIND = 3'd5
    } t_op;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] remainder;
    } t_mod_rsp;

endpackage

>>> rtl/fatca_mod_unit.sv
module fatca_mod_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fatca_pkg::t_mod_req i_req,
    output fatca_pkg::t_mod_rsp o_rsp
);
    import fatca_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   s_trial;
    logic [DATA_W:0]   s_diff;
    logic              s_ge;

    // One quotient bit per cycle, restoring form
    assign s_trial = {r_rem, r_dvd[DATA_W-1]};
    assign s_ge    = s_trial >= {1'b0, r_div};
    assign s_diff  = s_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_diff[DATA_W-1:0] : s_trial[DATA_W-1:0];
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

>>> rtl/fat16_cluster_allocator.sv
// FAT16 cluster allocation table with a next-fit hint. The table (TABLE_DEPTH entries of
// 16 bits) lives in one single-port-write, registered-read memory; operations read or write
// it one entry at a time. After reset the block sweeps the whole memory, one entry per
// cycle (entries 0 and 1 get 0xFFF8 and 0xFFFF, the rest zero); o_in_stall stays high
// meanwhile, but cluster_total can be written. One item is in work at a time. Write,
// rewind and unknown codes need no table read; read does one registered table read;
// allocate first folds a hint that lies past the end back into range with the 16-step
// remainder unit, then probes from the hint, wrapping through the data area, until one
// probe finds a free entry or cluster_total probes have been made; free chain does one
// read and one write-back per link; count free probes all cluster_total data entries.
// The single memory read port takes one probe per cycle. A finished result waits in the
// output register, and the next item is accepted while it waits.
`include "fat16_cluster_allocator_macros.svh"

module fat16_cluster_allocator #(
    parameter int TABLE_DEPTH = fatca_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item in
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [2:0]                     i_operation,
    input  logic [fatca_pkg::DATA_W-1:0]   i_cluster,
    input  logic [fatca_pkg::DATA_W-1:0]   i_entry_value,
    // result out
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fatca_pkg::DATA_W-1:0]   o_result_value,
    output logic                           o_success,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fatca_pkg::APB_AW-1:0]   paddr,
    input  logic [fatca_pkg::APB_DW-1:0]   pwdata,
    output logic [fatca_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);
    import fatca_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [DATA_W:0] DEPTH_EXT = (DATA_W + 1)'(TABLE_DEPTH);

    typedef enum logic [7:0] {
        ST_CLEAR     = 8'b0000_0001,
        ST_IDLE      = 8'b0000_0010,
        ST_MOD       = 8'b0000_0100,
        ST_SCAN      = 8'b0000_1000,
        ST_READ_DATA = 8'b0001_0000,
        ST_FREE_RD   = 8'b0010_0000,
        ST_FREE_WR   = 8'b0100_0000,
        ST_RESP      = 8'b1000_0000
    } t_state;

    function automatic logic f_in_table(input logic [DATA_W:0] c);
        return c < DEPTH_EXT;
    endfunction

    // Table memory
    logic [DATA_W-1:0] r_table [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [DATA_W-1:0] s_wdata;
    logic              s_re;
    logic [AW-1:0]     s_raddr;

    // Control and working registers; probe addresses carry one extra bit so that
    // cluster_total+1 can exceed the 16-bit range
    t_state            r_state,     n_state;
    logic [AW-1:0]     r_clr,       n_clr;
    logic [DATA_W-1:0] r_hint,      n_hint;
    logic [DATA_W-1:0] r_total,     n_total;
    logic              r_chk_valid, n_chk_valid;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_op,        n_op;
    logic [DATA_W-1:0] r_cluster,   n_cluster;
    logic [DATA_W:0]   r_addr,      n_addr;
    logic [DATA_W:0]   r_chk_addr,  n_chk_addr;
    logic [DATA_W-1:0] r_n,         n_n;
    logic [DATA_W-1:0] r_count,     n_count;
    logic [DATA_W-1:0] r_res_value, n_res_value;
    logic              r_res_ok,    n_res_ok;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_ok,    n_out_ok;

    t_mod_req          s_mod_req;
    t_mod_rsp          s_mod_rsp;

    logic              s_accept;
    logic              s_cfg_wr;
    logic [DATA_W-1:0] s_hint_off;
    logic [DATA_W:0]   s_total_end;
    logic [DATA_W:0]   s_addr_inc;
    logic [DATA_W:0]   s_chk_inc;
    logic              s_hit;
    logic              s_issue;

    fatca_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_mod_req),
        .o_rsp   (s_mod_rsp)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign s_accept   = i_in_valid && !o_in_stall;

    // Register port: a single register, always ready
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_AW-1] == REG_CLUSTER_TOTAL);
    assign prdata   = (paddr[APB_AW-1] == REG_CLUSTER_TOTAL)
                      ? {{(APB_DW - DATA_W){1'b0}}, r_total} : '0;

    assign s_hint_off  = r_hint - FIRST_DATA;
    assign s_total_end = {1'b0, r_total} + 17'd2;
    assign s_addr_inc  = r_addr + 17'd1;
    assign s_chk_inc   = r_chk_addr + 17'd1;

    // Probe returning this cycle is free; probes outside the table count as used
    assign s_hit   = r_chk_valid && f_in_table(r_chk_addr) && (r_rd_data == '0);
    assign s_issue = (r_n != r_total);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hint      = r_hint;
        n_total     = s_cfg_wr ? pwdata[DATA_W-1:0] : r_total;
        n_chk_valid = r_chk_valid;
        n_op        = r_op;
        n_cluster   = r_cluster;
        n_addr      = r_addr;
        n_chk_addr  = r_chk_addr;
        n_n         = r_n;
        n_count     = r_count;
        n_res_value = r_res_value;
        n_res_ok    = r_res_ok;
        n_out_value = r_out_value;
        n_out_ok    = r_out_ok;
        // drop the result once taken
        n_out_valid = r_out_valid && i_out_stall;

        s_we    = 1'b0;
        s_waddr = r_cluster[AW-1:0];
        s_wdata = '0;
        s_re    = 1'b0;
        s_raddr = r_cluster[AW-1:0];

        s_mod_req.start    = 1'b0;
        s_mod_req.dividend = s_hint_off;
        s_mod_req.divisor  = r_total;

        unique case (r_state)
            ST_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                if (r_clr == AW'(0)) begin
                    s_wdata = MEDIA_MARK;
                end else if (r_clr == AW'(1)) begin
                    s_wdata = END_MARK;
                end
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            ST_IDLE: begin
                if (s_accept) begin
                    n_op        = i_operation;
                    n_cluster   = i_cluster;
                    n_res_value = '0;
                    n_res_ok    = 1'b0;
                    n_chk_valid = 1'b0;
                    n_n         = '0;
                    n_count     = '0;
                    n_state     = ST_RESP;
                    case (i_operation)
                        OP_ALLOC: begin
                            // start the search at 2 + (hint - 2) mod total
                            if (r_total == '0) begin
                                n_addr  = {1'b0, FIRST_DATA};
                                n_state = ST_SCAN;
                            end else if (s_hint_off < r_total) begin
                                n_addr  = {1'b0, r_hint};
                                n_state = ST_SCAN;
                            end else begin
                                s_mod_req.start = 1'b1;
                                n_state         = ST_MOD;
                            end
                        end
                        OP_READ: begin
                            if (f_in_table({1'b0, i_cluster})) begin
                                s_re    = 1'b1;
                                s_raddr = i_cluster[AW-1:0];
                                n_state = ST_READ_DATA;
                            end
                        end
                        OP_WRITE: begin
                            if (f_in_table({1'b0, i_cluster})) begin
                                s_we     = 1'b1;
                                s_waddr  = i_cluster[AW-1:0];
                                s_wdata  = i_entry_value;
                                n_res_ok = 1'b1;
                            end
                        end
                        OP_FREE: begin
                            n_state = ST_FREE_RD;
                        end
                        OP_COUNT: begin
                            n_addr  = {1'b0, FIRST_DATA};
                            n_state = ST_SCAN;
                        end
                        OP_REWIND: begin
                            n_hint   = FIRST_DATA;
                            n_res_ok = 1'b1;
                        end
                        default: begin
                            n_res_ok = 1'b0;
                        end
                    endcase
                end
            end

            ST_MOD: begin
                if (s_mod_rsp.done) begin
                    n_addr  = {1'b0, s_mod_rsp.remainder + FIRST_DATA};
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue one probe and check the previous one every cycle
                if (s_hit && (r_op == OP_ALLOC)) begin
                    s_we        = 1'b1;
                    s_waddr     = r_chk_addr[AW-1:0];
                    s_wdata     = END_MARK;
                    // wrap the hint past the data area or past the last cluster number
                    n_hint      = ((s_chk_inc == s_total_end) || s_chk_inc[DATA_W])
                                  ? FIRST_DATA : s_chk_inc[DATA_W-1:0];
                    n_res_value = r_chk_addr[DATA_W-1:0];
                    n_res_ok    = 1'b1;
                    n_chk_valid = 1'b0;
                    n_state     = ST_RESP;
                end else begin
                    if (s_hit) begin
                        n_count = r_count + 1'b1;
                    end
                    if (s_issue) begin
                        s_re        = 1'b1;
                        s_raddr     = r_addr[AW-1:0];
                        n_chk_addr  = r_addr;
                        n_chk_valid = 1'b1;
                        n_addr      = (s_addr_inc == s_total_end) ? {1'b0, FIRST_DATA}
                                                                   : s_addr_inc;
                        n_n         = r_n + 1'b1;
                    end else begin
                        n_chk_valid = 1'b0;
                        if (!r_chk_valid) begin
                            // every candidate checked
                            if (r_op == OP_ALLOC) begin
                                n_res_value = '0;
                                n_res_ok    = 1'b0;
                            end else begin
                                n_res_value = r_count;
                                n_res_ok    = 1'b1;
                            end
                            n_state = ST_RESP;
                        end
                    end
                end
            end

            ST_READ_DATA: begin
                n_res_value = r_rd_data;
                n_res_ok    = 1'b1;
                n_state     = ST_RESP;
            end

            ST_FREE_RD: begin
                if ((r_cluster < FIRST_DATA) || (r_cluster >= END_MIN)) begin
                    n_res_value = r_count;
                    n_res_ok    = 1'b1;
                    n_state     = ST_RESP;
                end else if (!f_in_table({1'b0, r_cluster})) begin
                    // link leaves the table: stop the walk
                    n_res_value = r_count;
                    n_res_ok    = 1'b0;
                    n_state     = ST_RESP;
                end else begin
                    s_re    = 1'b1;
                    s_raddr = r_cluster[AW-1:0];
                    n_state = ST_FREE_WR;
                end
            end

            ST_FREE_WR: begin
                // zero the entry, follow its link next
                s_we      = 1'b1;
                s_waddr   = r_cluster[AW-1:0];
                s_wdata   = '0;
                if (r_cluster < r_hint) begin
                    n_hint = r_cluster;
                end
                n_count   = r_count + 1'b1;
                n_cluster = r_rd_data;
                n_state   = ST_FREE_RD;
            end

            ST_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_ok    = r_res_ok;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_hint      <= FIRST_DATA;
            r_total     <= TOTAL_RESET;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_total     <= n_total;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_cluster   <= n_cluster;
        r_addr      <= n_addr;
        r_chk_addr  <= n_chk_addr;
        r_n         <= n_n;
        r_count     <= n_count;
        r_res_value <= n_res_value;
        r_res_ok    <= n_res_ok;
        r_out_value <= n_out_value;
        r_out_ok    <= n_out_ok;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_table[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_rd_data <= r_table[s_raddr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_success      = r_out_ok;

    `FATCA_ASSERT_IMPLIES(a_mod_done_in_mod, i_clk, i_rst_n, s_mod_rsp.done, r_state == ST_MOD)
    `FATCA_ASSERT_IMPLIES(a_hint_floor, i_clk, i_rst_n, r_state != ST_CLEAR, r_hint >= FIRST_DATA)
    `FATCA_ASSERT_IMPLIES(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_n <= r_total)
    `FATCA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_accept, r_state != ST_IDLE)

endmodule

>>> dv/fat_table_checker.sv
`timescale 1ns / 1ps

module fat_table_checker #(
    parameter int TABLE_DEPTH = fatca_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic [2:0]                     i_operation,
    input  logic [fatca_pkg::DATA_W-1:0]   i_cluster,
    input  logic [fatca_pkg::DATA_W-1:0]   i_entry_value,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [fatca_pkg::DATA_W-1:0]   o_result_value,
    input  logic                           o_success,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fatca_pkg::APB_AW-1:0]   paddr,
    input  logic [fatca_pkg::APB_DW-1:0]   pwdata,
    input  logic [fatca_pkg::APB_DW-1:0]   prdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import fatca_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ok;
    } t_fat_result;

    // Shadow copy of the allocation table, hint and volume size
    logic [DATA_W-1:0] fat_table [TABLE_DEPTH];
    int unsigned       hint;
    int unsigned       total;

    t_fat_result awaited_results [$];
    t_fat_result want;
    int          fails   = 0;
    int          checked = 0;

    function automatic void clear_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++) fat_table[i] = '0;
        fat_table[0] = MEDIA_MARK;
        fat_table[1] = END_MARK;
        hint  = FIRST_DATA;
        total = TOTAL_RESET;
    endfunction

    // Next-fit search over 2 .. total+1, starting from the hint folded into range
    function automatic t_fat_result predict_allocate();
        int unsigned n;
        int unsigned c;
        t_fat_result r;
        r = '0;
        for (n = 0; n < total; n++) begin
            c = FIRST_DATA + ((hint - FIRST_DATA) + n) % total;
            if (c < TABLE_DEPTH && fat_table[c] == '0) begin
                fat_table[c] = END_MARK;
                if (c + 1 >= total + 2 || c + 1 > 32'h0000_FFFF) hint = FIRST_DATA;
                else hint = c + 1;
                r.value = c[DATA_W-1:0];
                r.ok    = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    // Walk the chain while the link is a data cluster, zeroing as it goes
    function automatic t_fat_result predict_free_chain(int unsigned start);
        int unsigned c;
        int unsigned nxt;
        int unsigned freed;
        t_fat_result r;
        c     = start;
        freed = 0;
        r     = '0;
        r.ok  = 1'b1;
        while (c >= FIRST_DATA && c < END_MIN) begin
            if (c >= TABLE_DEPTH) begin
                r.ok = 1'b0;
                break;
            end
            nxt          = fat_table[c];
            fat_table[c] = '0;
            if (c < hint) hint = c;
            freed++;
            c = nxt;
        end
        r.value = freed[DATA_W-1:0];
        return r;
    endfunction

    function automatic t_fat_result predict_free_count();
        int unsigned c;
        int unsigned count;
        t_fat_result r;
        count = 0;
        for (c = FIRST_DATA; c < total + 2; c++) begin
            if (c < TABLE_DEPTH && fat_table[c] == '0) count++;
        end
        r.value = count[DATA_W-1:0];
        r.ok    = 1'b1;
        return r;
    endfunction

    function automatic t_fat_result apply_operation(logic [2:0] op, logic [DATA_W-1:0] cl,
                                                    logic [DATA_W-1:0] val);
        t_fat_result r;
        r = '0;
        case (op)
            OP_ALLOC:  r = predict_allocate();
            OP_READ: begin
                if (int'(cl) < TABLE_DEPTH) begin
                    r.value = fat_table[cl];
                    r.ok    = 1'b1;
                end
            end
            OP_WRITE: begin
                if (int'(cl) < TABLE_DEPTH) begin
                    fat_table[cl] = val;
                    r.ok          = 1'b1;
                end
            end
            OP_FREE:   r = predict_free_chain(cl);
            OP_COUNT:  r = predict_free_count();
            OP_REWIND: begin
                hint = FIRST_DATA;
                r.ok = 1'b1;
            end
            default:   r = '0;
        endcase
        return r;
    endfunction

    task automatic note_failure(string what);
        if (fails < 10) $display("[%0t] check failed: %s", $time, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
        end else begin
            // Retire results before taking in a new item: a result can never
            // belong to an item accepted at the same edge
            if (o_out_valid && !i_out_stall) begin
                checked++;
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result value=%h success=%b with no item waiting",
                                           o_result_value, o_success));
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result_value !== want.value || o_success !== want.ok)
                        note_failure($sformatf("expected value=%h success=%b, got value=%h success=%b",
                                               want.value, want.ok, o_result_value, o_success));
                end
            end
            if (i_in_valid && !o_in_stall)
                awaited_results.push_back(apply_operation(i_operation, i_cluster, i_entry_value));
            if (psel && penable && pready && paddr[APB_AW-1] == REG_CLUSTER_TOTAL) begin
                if (pwrite) total = pwdata[DATA_W-1:0];
                else if (prdata !== APB_DW'(total))
                    note_failure($sformatf("cluster_total read expected %h, got %h",
                                           total, prdata));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> dv/fat16_cluster_allocator_tb.sv
`timescale 1ns / 1ps

module fat16_cluster_allocator_tb;
    import fatca_pkg::*;

    localparam int          TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int unsigned TOTAL_MAX   = 65524;
    // Operation codes the block does not know; they must be answered as failures
    localparam logic [2:0]  OP_BAD_LO   = 3'd6;
    localparam logic [2:0]  OP_BAD_HI   = 3'd7;
    localparam logic [APB_AW-1:0] ADDR_CLUSTER_TOTAL = '0;
    // Watchdog limit, set well above the slowest honest run
    localparam int          CYCLE_LIMIT = 4_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [2:0]          i_operation = '0;
    logic [DATA_W-1:0]   i_cluster = '0;
    logic [DATA_W-1:0]   i_entry_value = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DATA_W-1:0]   o_result_value;
    logic                o_success;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int          fail_count;
    int          pending;
    int          checked;
    int          cycles = 0;
    int          n_sent = 0;
    int          n_settings = 0;
    int          count_budget = 0;
    int          stall_left = 0;
    int unsigned cur_total = TOTAL_RESET;
    bit          calm = 1'b0;

    fat16_cluster_allocator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_cluster(i_cluster), .i_entry_value(i_entry_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_value(o_result_value), .o_success(o_success),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fat_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_cluster(i_cluster), .i_entry_value(i_entry_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_value(o_result_value), .o_success(o_success),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs anywhere
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result-side back-pressure: random stall runs, none at all while calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (!calm && $urandom_range(99) < 25) begin
            i_out_stall <= 1'b1;
            stall_left  <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // A cluster number inside the current data area
    function automatic logic [DATA_W-1:0] data_cluster();
        if (cur_total == 0) return FIRST_DATA;
        return DATA_W'($urandom_range(cur_total + 1, FIRST_DATA));
    endfunction

    // Offer one item after an optional gap and hold it until it is taken
    task automatic send_item(logic [2:0] op, logic [DATA_W-1:0] cl, logic [DATA_W-1:0] val);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_cluster     <= cl;
        i_entry_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Wait until no result is outstanding, write cluster_total, then read it back for the checker
    task automatic set_total(int unsigned value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CLUSTER_TOTAL;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_total = value;
        n_settings++;
        // Counting walks the whole data area, so ration it on big volumes
        if (value > 5000)     count_budget = 1;
        else if (value > 600) count_budget = 2;
        else                  count_budget = 1000;
    endtask

    // Well-formed traffic: link a short chain by writes, maybe allocate
    // alongside, maybe peek at it, then free it from the head or a later link
    task automatic chain_sequence();
        logic [DATA_W-1:0] link [6];
        logic [DATA_W-1:0] tail;
        int                len;
        int                k;
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) link[k] = data_cluster();
        for (k = 0; k < len; k++) begin
            if (k < len - 1)                tail = link[k + 1];
            else if ($urandom_range(3) > 0) tail = END_MARK;
            else                            tail = DATA_W'($urandom_range(32'hFFFF, END_MIN));
            send_item(OP_WRITE, link[k], tail);
            if ($urandom_range(5) == 0)
                send_item(OP_ALLOC, DATA_W'($urandom()), DATA_W'($urandom()));
        end
        if ($urandom_range(2) == 0)
            send_item(OP_READ, link[$urandom_range(len - 1)], DATA_W'($urandom()));
        k = ($urandom_range(3) == 0) ? $urandom_range(len - 1) : 0;
        send_item(OP_FREE, link[k], DATA_W'($urandom()));
    endtask

    // Single items, every operation, with the odd wild cluster or value
    task automatic random_item();
        int unsigned       r;
        logic [DATA_W-1:0] cl;
        logic [DATA_W-1:0] val;
        r  = $urandom_range(99);
        cl = ($urandom_range(9) < 8) ? data_cluster() : DATA_W'($urandom());
        case ($urandom_range(2))
            0:       val = '0;
            1:       val = data_cluster();
            default: val = DATA_W'($urandom());
        endcase
        if (r < 26) begin
            send_item(OP_ALLOC, DATA_W'($urandom()), DATA_W'($urandom()));
        end else if (r < 42) begin
            send_item(OP_READ, cl, DATA_W'($urandom()));
        end else if (r < 58) begin
            send_item(OP_WRITE, cl, val);
        end else if (r < 70) begin
            send_item(OP_FREE, cl, DATA_W'($urandom()));
        end else if (r < 78) begin
            if (count_budget > 0) begin
                count_budget--;
                send_item(OP_COUNT, DATA_W'($urandom()), DATA_W'($urandom()));
            end else begin
                send_item(OP_READ, cl, val);
            end
        end else if (r < 86) begin
            send_item(OP_REWIND, DATA_W'($urandom()), DATA_W'($urandom()));
        end else if (r < 92) begin
            send_item($urandom_range(1) ? OP_BAD_HI : OP_BAD_LO, cl, val);
        end else begin
            send_item(OP_WRITE, DATA_W'($urandom()), DATA_W'($urandom()));
        end
    endtask

    // Volume sizes: often small so the table fills and wraps, some medium,
    // and now and then the reset size, a single cluster or the largest
    function automatic int unsigned pick_total();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return $urandom_range(24, 1);
        if (r < 75) return $urandom_range(300, 25);
        if (r < 85) return $urandom_range(5000, 301);
        if (r < 92) return 1;
        if (r < 96) return TOTAL_RESET;
        return TOTAL_MAX;
    endfunction

    initial begin
        int phase;
        int target;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The register write lands while the table is still
        // being cleared; items then wait on the input stall.
        calm = 1'b1;
        set_total(4);
        send_item(OP_READ, 16'h0000, 16'h0000);     // reserved media entry
        send_item(OP_READ, 16'h0001, 16'hFFFF);     // reserved end entry
        send_item(OP_READ, 16'hFFFF, 16'h0000);     // last entry of the table
        repeat (5) send_item(OP_ALLOC, 16'h0000, 16'h0000);   // fill, then table full
        send_item(OP_COUNT, 16'h0000, 16'h0000);
        send_item(OP_WRITE, 16'h0002, 16'h0004);
        send_item(OP_WRITE, 16'h0004, 16'h0005);
        send_item(OP_FREE, 16'h0002, 16'h0000);     // three links; the hint is already at 2
        send_item(OP_WRITE, 16'h0003, 16'h0003);    // self loop
        send_item(OP_FREE, 16'h0003, 16'h0000);
        send_item(OP_FREE, 16'h0000, 16'h0000);     // start below the data area
        send_item(OP_FREE, END_MIN, 16'h0000);      // start at an end code
        send_item(OP_FREE, END_MIN - 16'd1, 16'h0000);
        send_item(OP_WRITE, 16'h0000, 16'h1234);
        send_item(OP_WRITE, 16'hFFFF, 16'hFFFF);
        send_item(OP_REWIND, 16'hFFFF, 16'hFFFF);
        send_item(OP_BAD_LO, 16'h0002, 16'h0000);
        send_item(OP_BAD_HI, 16'hFFFF, 16'hFFFF);
        send_item(OP_COUNT, 16'h0000, 16'h0000);
        repeat (2) send_item(OP_ALLOC, 16'h0000, 16'h0000);   // leave the hint at 4

        set_total(0);                                // empty volume
        send_item(OP_ALLOC, 16'h0000, 16'h0000);
        send_item(OP_COUNT, 16'h0000, 16'h0000);

        set_total(1);                                // hint now lies past the end
        send_item(OP_ALLOC, 16'h0000, 16'h0000);
        send_item(OP_WRITE, 16'h0002, 16'h0000);
        send_item(OP_ALLOC, 16'h0000, 16'h0000);

        set_total(TOTAL_MAX);
        send_item(OP_ALLOC, 16'h0000, 16'h0000);
        send_item(OP_COUNT, 16'h0000, 16'h0000);
        send_item(OP_FREE, 16'h0002, 16'h0000);

        // Random part: a dozen volume sizes, each with a burst of traffic
        for (phase = 0; phase < 12; phase++) begin
            set_total(pick_total());
            calm   = ($urandom_range(3) == 0);
            target = n_sent + 95 + $urandom_range(10);
            while (n_sent < target) begin
                if ($urandom_range(99) < 60) chain_sequence();
                else                         random_item();
            end
        end

        // Back to the reset size to finish
        set_total(TOTAL_RESET);
        calm = 1'b0;
        repeat (20) random_item();

        drain();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d items over %0d cluster_total settings; %0d results compared.",
                 n_sent, n_settings, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d results still awaited", fail_count, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
